@@ rtl/tftp_rr_pkg.sv @@
// shared constants and widths for the tftp read receiver
`default_nettype none

package tftp_rr_pkg;

  // field widths
  localparam int MODE_W   = 2;
  localparam int OPCODE_W = 16;
  localparam int BLOCK_W  = 16;
  localparam int PLEN_W   = 12;
  localparam int DIGIT_W  = 8;
  localparam int KIND_W   = 2;
  localparam int WORD_W   = 32;
  localparam int RETRY_W  = 8;
  localparam int CFG_W    = 31;
  localparam int CFG_IDX_W = 2;
  localparam int PHASE_W  = 3;

  // stream packing
  localparam int S_TDATA_W = 56;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 96;
  localparam int M_TUSER_W = 4;

  // default block sizes and option ack length
  localparam int SINGLE_BLOCK_DEF       = 1450;
  localparam int DOUBLE_BLOCK_DEF       = 2904;
  localparam int MIN_OPTION_ACK_LEN_DEF = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WANT_DOUBLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES    = 2'd3;

  // configuration reset values
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 8'd3;
  localparam logic [CFG_W-1:0]   MAX_BYTES_RST   = 31'd1048576;

  // event modes
  localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PACKET  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;

  // transfer phases
  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_REQUEST = 3'd1;
  localparam logic [PHASE_W-1:0] PH_RECEIVE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DONE    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_FAILED  = 3'd4;

  // packet opcodes and option digits
  localparam logic [OPCODE_W-1:0] OP_DATA = 16'd3;
  localparam logic [OPCODE_W-1:0] OP_OACK = 16'd6;
  localparam logic [DIGIT_W-1:0]  DIGIT_ONE = 8'h31;
  localparam logic [DIGIT_W-1:0]  DIGIT_TWO = 8'h32;
  localparam logic [PLEN_W-1:0]   HEADER_LEN = 12'd4;

  // result codes
  localparam logic [KIND_W-1:0] SEND_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] SEND_REQUEST = 2'd1;
  localparam logic [KIND_W-1:0] SEND_ACK     = 2'd2;

  localparam logic [KIND_W-1:0] PAY_DISCARD = 2'd0;
  localparam logic [KIND_W-1:0] PAY_FULL    = 2'd1;
  localparam logic [KIND_W-1:0] PAY_FINAL   = 2'd2;

  localparam logic [KIND_W-1:0] STAT_BUSY   = 2'd0;
  localparam logic [KIND_W-1:0] STAT_DONE   = 2'd1;
  localparam logic [KIND_W-1:0] STAT_FAILED = 2'd2;

  // one result item
  typedef struct packed {
    logic [KIND_W-1:0]  send_kind;
    logic [BLOCK_W-1:0] ack_number;
    logic [KIND_W-1:0]  payload_kind;
    logic [WORD_W-1:0]  write_offset;
    logic [PLEN_W-1:0]  payload_length;
    logic [KIND_W-1:0]  status;
    logic [WORD_W-1:0]  bytes_total;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/tftp_read_receiver_top.sv @@
// tftp read receiver: client-side read transfer control with block-size option
// an accepted input transaction passes the input register, then the result register,
// before its result shows on m_*; events that give no result emit nothing
// throughput: one input transaction per cycle; the input register advances whenever
// the result register is empty or being taken, and all state updates in that cycle
// reset: synchronous active-high rst clears both registers' valid flags and the transfer
// state (phase idle) and loads the configuration registers with their default values
`default_nettype none

module tftp_read_receiver_top #(
  parameter int SINGLE_BLOCK       = tftp_rr_pkg::SINGLE_BLOCK_DEF,
  parameter int DOUBLE_BLOCK       = tftp_rr_pkg::DOUBLE_BLOCK_DEF,
  parameter int MIN_OPTION_ACK_LEN = tftp_rr_pkg::MIN_OPTION_ACK_LEN_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // configuration write port
  input  wire logic                                  cfg_we,
  input  wire logic [tftp_rr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tftp_rr_pkg::CFG_W-1:0]         cfg_data,
  // event stream
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // opcode[15:0], block_number[31:16], packet_length[43:32], option_digit[51:44]
  input  wire logic [tftp_rr_pkg::S_TDATA_W-1:0]     s_tdata,
  // mode[1:0]
  input  wire logic [tftp_rr_pkg::S_TUSER_W-1:0]     s_tuser,
  // result stream
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // ack_number[15:0], write_offset[47:16], payload_length[59:48], status[61:60],
  // bytes_total[93:62]
  output logic [tftp_rr_pkg::M_TDATA_W-1:0]          m_tdata,
  // send_kind[1:0], payload_kind[3:2]
  output logic [tftp_rr_pkg::M_TUSER_W-1:0]          m_tuser
);

  localparam int PW = tftp_rr_pkg::PLEN_W;
  localparam int WW = tftp_rr_pkg::WORD_W;

  // configuration registers
  logic [tftp_rr_pkg::RETRY_W-1:0] retry_limit;
  logic                            want_double_block;
  logic [tftp_rr_pkg::CFG_W-1:0]   start_offset;
  logic [tftp_rr_pkg::CFG_W-1:0]   max_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit       <= tftp_rr_pkg::RETRY_LIMIT_RST;
      want_double_block <= 1'b0;
      start_offset      <= '0;
      max_bytes         <= tftp_rr_pkg::MAX_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tftp_rr_pkg::CFG_RETRY_LIMIT:  retry_limit <= cfg_data[tftp_rr_pkg::RETRY_W-1:0];
        tftp_rr_pkg::CFG_WANT_DOUBLE:  want_double_block <= cfg_data[0];
        tftp_rr_pkg::CFG_START_OFFSET: start_offset <= cfg_data;
        tftp_rr_pkg::CFG_MAX_BYTES:    max_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic                                in_valid;
  logic [tftp_rr_pkg::MODE_W-1:0]      in_mode;
  logic [tftp_rr_pkg::OPCODE_W-1:0]    in_opcode;
  logic [tftp_rr_pkg::BLOCK_W-1:0]     in_block;
  logic [PW-1:0]                       in_plen;
  logic [tftp_rr_pkg::DIGIT_W-1:0]     in_digit;
  logic                                advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode   <= s_tuser[1:0];
      in_opcode <= s_tdata[15:0];
      in_block  <= s_tdata[31:16];
      in_plen   <= s_tdata[43:32];
      in_digit  <= s_tdata[51:44];
    end
  end

  // transfer state
  logic [tftp_rr_pkg::PHASE_W-1:0]  phase, phase_next;
  logic [tftp_rr_pkg::RETRY_W-1:0]  retry_count, retry_count_next;
  logic                             double_in_force, double_in_force_next;
  logic                             option_ack_seen, option_ack_seen_next;
  logic [tftp_rr_pkg::BLOCK_W-1:0]  pending_ack, pending_ack_next;
  logic [WW-1:0]                    byte_total, byte_total_next;

  // datapath terms for a data packet
  logic [PW-1:0]  dlen;
  logic [PW-1:0]  bsize;
  logic [WW-1:0]  sum_total;
  logic [WW-1:0]  blk_m1;
  logic [WW-1:0]  offs_prod;
  logic [WW-1:0]  offs;
  logic           size_sel;
  logic           oack_long;

  assign dlen      = in_plen - tftp_rr_pkg::HEADER_LEN;
  assign bsize     = double_in_force ? PW'(DOUBLE_BLOCK) : PW'(SINGLE_BLOCK);
  assign sum_total = byte_total + {{(WW-PW){1'b0}}, dlen};
  assign blk_m1    = {{(WW-tftp_rr_pkg::BLOCK_W){1'b0}}, in_block} - {{(WW-1){1'b0}}, 1'b1};
  assign offs_prod = blk_m1 * {{(WW-PW){1'b0}}, bsize};
  assign offs      = offs_prod + {1'b0, start_offset};
  assign oack_long = (in_plen >= PW'(MIN_OPTION_ACK_LEN));

  // block size after option ack correction
  always_comb begin
    size_sel = double_in_force;
    if (want_double_block && (in_digit == tftp_rr_pkg::DIGIT_ONE)) begin
      size_sel = 1'b0;
    end else if (!want_double_block && (in_digit == tftp_rr_pkg::DIGIT_TWO)) begin
      size_sel = 1'b1;
    end
  end

  // event handling
  logic                  has_result;
  tftp_rr_pkg::result_t  res;
  logic                  as_timeout;

  always_comb begin
    phase_next           = phase;
    retry_count_next     = retry_count;
    double_in_force_next = double_in_force;
    option_ack_seen_next = option_ack_seen;
    pending_ack_next     = pending_ack;
    byte_total_next      = byte_total;
    has_result           = 1'b0;
    as_timeout           = 1'b0;
    res                  = '0;

    if (in_mode == tftp_rr_pkg::MODE_START) begin
      has_result           = 1'b1;
      double_in_force_next = want_double_block;
      option_ack_seen_next = 1'b0;
      pending_ack_next     = '0;
      byte_total_next      = '0;
      if (retry_limit == '0) begin
        phase_next       = tftp_rr_pkg::PH_FAILED;
        retry_count_next = '0;
        res.status       = tftp_rr_pkg::STAT_FAILED;
      end else begin
        phase_next       = tftp_rr_pkg::PH_REQUEST;
        retry_count_next = 8'd1;
        res.send_kind    = tftp_rr_pkg::SEND_REQUEST;
      end
    end else if ((in_mode == tftp_rr_pkg::MODE_PACKET || in_mode == tftp_rr_pkg::MODE_TIMEOUT)
                 && (phase == tftp_rr_pkg::PH_REQUEST || phase == tftp_rr_pkg::PH_RECEIVE)) begin
      if (in_mode == tftp_rr_pkg::MODE_TIMEOUT) begin
        as_timeout = 1'b1;
      end else if (phase == tftp_rr_pkg::PH_REQUEST) begin
        // waiting for the first option ack
        if (oack_long && in_opcode == tftp_rr_pkg::OP_OACK) begin
          has_result           = 1'b1;
          double_in_force_next = size_sel;
          phase_next           = tftp_rr_pkg::PH_RECEIVE;
          pending_ack_next     = '0;
          retry_count_next     = 8'd1;
          res.send_kind        = tftp_rr_pkg::SEND_ACK;
        end
      end else if (in_plen < tftp_rr_pkg::HEADER_LEN) begin
        // runt packet counts as a timeout
        as_timeout = 1'b1;
      end else if (in_opcode == tftp_rr_pkg::OP_DATA) begin
        has_result = 1'b1;
        if (dlen < bsize) begin
          // short block ends the transfer
          phase_next         = tftp_rr_pkg::PH_DONE;
          pending_ack_next   = in_block;
          res.send_kind      = tftp_rr_pkg::SEND_ACK;
          res.ack_number     = in_block;
          res.payload_kind   = tftp_rr_pkg::PAY_FINAL;
          res.payload_length = dlen;
          res.status         = tftp_rr_pkg::STAT_DONE;
        end else begin
          byte_total_next = sum_total;
          if (sum_total > {1'b0, max_bytes}) begin
            phase_next = tftp_rr_pkg::PH_FAILED;
            res.status = tftp_rr_pkg::STAT_FAILED;
          end else begin
            pending_ack_next   = in_block;
            retry_count_next   = 8'd1;
            res.send_kind      = tftp_rr_pkg::SEND_ACK;
            res.ack_number     = in_block;
            res.payload_kind   = tftp_rr_pkg::PAY_FULL;
            res.write_offset   = offs;
            res.payload_length = dlen;
          end
        end
      end else if (in_opcode == tftp_rr_pkg::OP_OACK) begin
        // first duplicate option ack is absorbed silently
        if (!option_ack_seen) begin
          option_ack_seen_next = 1'b1;
        end else if (oack_long) begin
          has_result           = 1'b1;
          double_in_force_next = size_sel;
          pending_ack_next     = '0;
          retry_count_next     = 8'd1;
          res.send_kind        = tftp_rr_pkg::SEND_ACK;
        end
      end
    end

    // retry or give up
    if (as_timeout) begin
      has_result = 1'b1;
      if (retry_count >= retry_limit) begin
        phase_next = tftp_rr_pkg::PH_FAILED;
        res.status = tftp_rr_pkg::STAT_FAILED;
      end else begin
        retry_count_next = retry_count + 8'd1;
        if (phase == tftp_rr_pkg::PH_REQUEST) begin
          res.send_kind = tftp_rr_pkg::SEND_REQUEST;
        end else begin
          res.send_kind  = tftp_rr_pkg::SEND_ACK;
          res.ack_number = pending_ack;
        end
      end
    end

    res.bytes_total = byte_total_next;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= tftp_rr_pkg::PH_IDLE;
      retry_count     <= '0;
      double_in_force <= 1'b0;
      option_ack_seen <= 1'b0;
      pending_ack     <= '0;
      byte_total      <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      retry_count     <= retry_count_next;
      double_in_force <= double_in_force_next;
      option_ack_seen <= option_ack_seen_next;
      pending_ack     <= pending_ack_next;
      byte_total      <= byte_total_next;
    end
  end

  // result register
  tftp_rr_pkg::result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= has_result;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.bytes_total, out_res.status, out_res.payload_length,
                    out_res.write_offset, out_res.ack_number};
  assign m_tuser = {out_res.payload_kind, out_res.send_kind};

  // checks on result consistency and state transitions
  a_final_is_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.payload_kind == tftp_rr_pkg::PAY_FINAL
    |-> out_res.status == tftp_rr_pkg::STAT_DONE && out_res.send_kind == tftp_rr_pkg::SEND_ACK)
    else $error("final block result without done status and ack");

  a_fail_sends_nothing: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.status == tftp_rr_pkg::STAT_FAILED
    |-> out_res.send_kind == tftp_rr_pkg::SEND_NONE
        && out_res.payload_kind == tftp_rr_pkg::PAY_DISCARD)
    else $error("failed result carries a send or payload");

  a_payload_acked: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.payload_kind != tftp_rr_pkg::PAY_DISCARD
    |-> out_res.send_kind == tftp_rr_pkg::SEND_ACK && out_res.ack_number == pending_ack)
    else $error("payload result without matching ack");

  a_start_enters_request: assert property (@(posedge clk) disable iff (rst)
    advance && in_mode == tftp_rr_pkg::MODE_START && retry_limit != '0
    |=> phase == tftp_rr_pkg::PH_REQUEST && retry_count == 8'd1 && m_tvalid)
    else $error("start did not enter request phase");

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    advance && in_mode != tftp_rr_pkg::MODE_START
    && (phase == tftp_rr_pkg::PH_IDLE || phase == tftp_rr_pkg::PH_DONE
        || phase == tftp_rr_pkg::PH_FAILED)
    |=> !m_tvalid && $stable(phase))
    else $error("event outside a transfer produced a result");

endmodule

`default_nettype wire

@@ tb/sv/tftp_read_receiver_top_tb.sv @@
// self-checking testbench for the tftp read receiver: directed table, then random transfers
`timescale 1ns / 100ps

module tftp_read_receiver_top_tb;
  import tftp_rr_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_PRINTS    = 40;
  localparam logic [WORD_W-1:0] SINGLE_SZ = SINGLE_BLOCK_DEF;
  localparam logic [WORD_W-1:0] DOUBLE_SZ = DOUBLE_BLOCK_DEF;
  localparam logic [PLEN_W-1:0] OACK_MIN  = MIN_OPTION_ACK_LEN_DEF;

  // one input transaction, unpacked
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [OPCODE_W-1:0] opcode;
    logic [BLOCK_W-1:0]  blk;
    logic [PLEN_W-1:0]   plen;
    logic [DIGIT_W-1:0]  digit;
  } rx_event_t;

  // directed table row: a register write or an event, optionally with a typed result
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_val;
    rx_event_t            ev;
    bit                   pinned;
    bit                   pinned_has;
    result_t              pinned_res;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  wire                  s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  wire                  m_tvalid;
  logic                 m_tready = 1'b0;
  wire  [M_TDATA_W-1:0] m_tdata;
  wire  [M_TUSER_W-1:0] m_tuser;

  tftp_read_receiver_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #CLK_HALF clk = ~clk;

  // register shadow
  logic [RETRY_W-1:0] lim_retries = RETRY_LIMIT_RST;
  bit                 want_big = 1'b0;
  logic [CFG_W-1:0]   base_offset = '0;
  logic [CFG_W-1:0]   byte_cap = MAX_BYTES_RST;

  // transfer state mirror
  logic [PHASE_W-1:0] xfer_phase = PH_IDLE;
  logic [RETRY_W-1:0] sends_made = '0;
  bit                 big_blocks = 1'b0;
  bit                 oack_absorbed = 1'b0;
  logic [BLOCK_W-1:0] ack_due = '0;
  logic [WORD_W-1:0]  payload_sum = '0;

  result_t   pending_replies[$];
  plan_row_t test_plan[$];
  int        error_count = 0;
  int        items_sent = 0;
  int        send_gap_pct = 10;
  int        recv_idle_pct = 53;
  int        stall_request = 0;
  int        hold_left = 0;
  bit        pin_now = 1'b0;
  bit        pin_has = 1'b0;
  result_t   pin_res = '0;

  task automatic log_mismatch(input string msg);
    if (error_count < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) log_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic rx_event_t ev_make(input logic [31:0] mode, input logic [31:0] opcode,
                                        input logic [31:0] blk, input logic [31:0] plen,
                                        input logic [31:0] digit);
    rx_event_t e;
    e.mode   = mode[MODE_W-1:0];
    e.opcode = opcode[OPCODE_W-1:0];
    e.blk    = blk[BLOCK_W-1:0];
    e.plen   = plen[PLEN_W-1:0];
    e.digit  = digit[DIGIT_W-1:0];
    return e;
  endfunction

  // typed result with nothing in the payload fields
  function automatic result_t pin_result(input logic [KIND_W-1:0] send,
                                         input logic [BLOCK_W-1:0] ack,
                                         input logic [KIND_W-1:0] stat,
                                         input logic [WORD_W-1:0] total);
    result_t r;
    r = '0;
    r.send_kind = send;
    r.ack_number = ack;
    r.payload_kind = PAY_DISCARD;
    r.status = stat;
    r.bytes_total = total;
    return r;
  endfunction

  function automatic result_t make_result(input logic [KIND_W-1:0] send,
                                          input logic [BLOCK_W-1:0] ack,
                                          input logic [KIND_W-1:0] pkind,
                                          input logic [WORD_W-1:0] offs,
                                          input logic [PLEN_W-1:0] plen,
                                          input logic [KIND_W-1:0] stat);
    result_t r;
    r.send_kind = send;
    r.ack_number = ack;
    r.payload_kind = pkind;
    r.write_offset = offs;
    r.payload_length = plen;
    r.status = stat;
    r.bytes_total = payload_sum;
    return r;
  endfunction

  // block size correction from the granted leading digit
  function automatic void apply_granted_size(input logic [DIGIT_W-1:0] digit);
    if (want_big && digit == DIGIT_ONE) big_blocks = 1'b0;
    else if (!want_big && digit == DIGIT_TWO) big_blocks = 1'b1;
  endfunction

  // resend the request or ack, or give up once the send budget is spent
  function automatic result_t retry_or_fail();
    if (sends_made >= lim_retries) begin
      xfer_phase = PH_FAILED;
      return make_result(SEND_NONE, '0, PAY_DISCARD, '0, '0, STAT_FAILED);
    end
    sends_made = sends_made + 1'b1;
    if (xfer_phase == PH_REQUEST)
      return make_result(SEND_REQUEST, '0, PAY_DISCARD, '0, '0, STAT_BUSY);
    return make_result(SEND_ACK, ack_due, PAY_DISCARD, '0, '0, STAT_BUSY);
  endfunction

  // advance the transfer by one event; returns 1 when the event yields a result
  function automatic bit advance_transfer(input rx_event_t ev, output result_t r);
    logic [PLEN_W-1:0] pay_len;
    logic [WORD_W-1:0] block_bytes;
    logic [WORD_W-1:0] offs;
    r = '0;
    if (ev.mode == MODE_START) begin
      sends_made = '0;
      big_blocks = want_big;
      oack_absorbed = 1'b0;
      ack_due = '0;
      payload_sum = '0;
      if (lim_retries == 0) begin
        xfer_phase = PH_FAILED;
        r = make_result(SEND_NONE, '0, PAY_DISCARD, '0, '0, STAT_FAILED);
        return 1'b1;
      end
      xfer_phase = PH_REQUEST;
      sends_made = 8'd1;
      r = make_result(SEND_REQUEST, '0, PAY_DISCARD, '0, '0, STAT_BUSY);
      return 1'b1;
    end
    if (ev.mode != MODE_PACKET && ev.mode != MODE_TIMEOUT) return 1'b0;
    if (xfer_phase != PH_REQUEST && xfer_phase != PH_RECEIVE) return 1'b0;
    if (ev.mode == MODE_TIMEOUT) begin
      r = retry_or_fail();
      return 1'b1;
    end
    // waiting for the option ack
    if (xfer_phase == PH_REQUEST) begin
      if (ev.plen < OACK_MIN || ev.opcode != OP_OACK) return 1'b0;
      apply_granted_size(ev.digit);
      xfer_phase = PH_RECEIVE;
      ack_due = '0;
      sends_made = 8'd1;
      r = make_result(SEND_ACK, '0, PAY_DISCARD, '0, '0, STAT_BUSY);
      return 1'b1;
    end
    // data phase; a runt counts as a timeout
    if (ev.plen < HEADER_LEN) begin
      r = retry_or_fail();
      return 1'b1;
    end
    if (ev.opcode == OP_DATA) begin
      pay_len = ev.plen - HEADER_LEN;
      block_bytes = big_blocks ? DOUBLE_SZ : SINGLE_SZ;
      if ({20'd0, pay_len} < block_bytes) begin
        xfer_phase = PH_DONE;
        ack_due = ev.blk;
        r = make_result(SEND_ACK, ev.blk, PAY_FINAL, '0, pay_len, STAT_DONE);
        return 1'b1;
      end
      payload_sum = payload_sum + {20'd0, pay_len};
      if (payload_sum > {1'b0, byte_cap}) begin
        xfer_phase = PH_FAILED;
        r = make_result(SEND_NONE, '0, PAY_DISCARD, '0, '0, STAT_FAILED);
        return 1'b1;
      end
      offs = ({16'd0, ev.blk} - 32'd1) * block_bytes + {1'b0, base_offset};
      ack_due = ev.blk;
      sends_made = 8'd1;
      r = make_result(SEND_ACK, ev.blk, PAY_FULL, offs, pay_len, STAT_BUSY);
      return 1'b1;
    end
    if (ev.opcode == OP_OACK) begin
      // the first repeat of the option ack is expected and swallowed
      if (!oack_absorbed) begin
        oack_absorbed = 1'b1;
        return 1'b0;
      end
      if (ev.plen < OACK_MIN) return 1'b0;
      apply_granted_size(ev.digit);
      ack_due = '0;
      sends_made = 8'd1;
      r = make_result(SEND_ACK, '0, PAY_DISCARD, '0, '0, STAT_BUSY);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // result check, then prediction for the input transaction of this edge
  always @(posedge clk) begin : scoreboard
    result_t   got;
    result_t   want;
    rx_event_t seen;
    bit        fires;
    if (!rst && m_tvalid && m_tready) begin
      got.send_kind      = m_tuser[1:0];
      got.payload_kind   = m_tuser[3:2];
      got.ack_number     = m_tdata[15:0];
      got.write_offset   = m_tdata[47:16];
      got.payload_length = m_tdata[59:48];
      got.status         = m_tdata[61:60];
      got.bytes_total    = m_tdata[93:62];
      if (pending_replies.size() == 0) begin
        log_mismatch("result transaction with nothing pending");
      end else begin
        want = pending_replies.pop_front();
        check_field("send_kind", got.send_kind, want.send_kind);
        check_field("ack_number", got.ack_number, want.ack_number);
        check_field("payload_kind", got.payload_kind, want.payload_kind);
        check_field("write_offset", got.write_offset, want.write_offset);
        check_field("payload_length", got.payload_length, want.payload_length);
        check_field("status", got.status, want.status);
        check_field("bytes_total", got.bytes_total, want.bytes_total);
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      seen = ev_make(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[43:32], s_tdata[51:44]);
      fires = advance_transfer(seen, want);
      if (pin_now) begin
        fires = pin_has;
        want = pin_res;
      end
      if (fires) pending_replies.push_back(want);
    end
  end

  // receiver: random back-pressure, plus long hold-offs on request
  always @(negedge clk) begin
    if (stall_request > 0) begin
      hold_left = stall_request;
      stall_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one event and wait until the block takes it
  task automatic offer_event(input rx_event_t ev, input bit pinned, input bit has,
                             input result_t res);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    pin_now = pinned;
    pin_has = has;
    pin_res = res;
    s_tvalid <= 1'b1;
    s_tuser <= ev.mode;
    s_tdata <= {4'd0, ev.digit, ev.plen, ev.blk, ev.opcode};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic offer(input rx_event_t ev);
    offer_event(ev, 1'b0, 1'b0, '0);
  endtask

  // drop valid and wait until the block has nothing left in flight
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_RETRY_LIMIT:  lim_retries = val[RETRY_W-1:0];
      CFG_WANT_DOUBLE:  want_big = val[0];
      CFG_START_OFFSET: base_offset = val;
      CFG_MAX_BYTES:    byte_cap = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void plan_pinned(input rx_event_t ev, input bit has, input result_t res);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_idx = '0;
    row.cfg_val = '0;
    row.ev = ev;
    row.pinned = 1'b1;
    row.pinned_has = has;
    row.pinned_res = res;
    test_plan.push_back(row);
  endfunction

  function automatic void plan_event(input rx_event_t ev);
    plan_pinned(ev, 1'b0, '0);
    test_plan[test_plan.size() - 1].pinned = 1'b0;
  endfunction

  function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    row.ev = '0;
    row.pinned = 1'b0;
    row.pinned_has = 1'b0;
    row.pinned_res = '0;
    test_plan.push_back(row);
  endfunction

  function automatic logic [31:0] pick_digit();
    logic [31:0] p;
    p = $urandom_range(99);
    if (p < 40) return DIGIT_ONE;
    if (p < 80) return DIGIT_TWO;
    return $urandom_range(255);
  endfunction

  function automatic rx_event_t random_event();
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom;
    b = $urandom;
    return ev_make(a[1:0], b[15:0], b[31:16], a[13:2], a[21:14]);
  endfunction

  // one well-formed transfer with random content and some noise mixed in
  task automatic random_transfer();
    logic [31:0] bsz;
    logic [15:0] blk_no;
    int          pick;
    offer(ev_make(MODE_START, 0, 0, 0, 0));
    while ($urandom_range(99) < 25) offer(ev_make(MODE_TIMEOUT, $urandom, $urandom, $urandom, 0));
    if ($urandom_range(99) < 15) offer(random_event());
    offer(ev_make(MODE_PACKET, OP_OACK, $urandom, $urandom_range(4095, OACK_MIN), pick_digit()));
    blk_no = ($urandom_range(99) < 80) ? 16'd1 : 16'($urandom);
    repeat ($urandom_range(10)) begin
      bsz = big_blocks ? DOUBLE_SZ : SINGLE_SZ;
      pick = $urandom_range(99);
      if (pick < 65) begin
        offer(ev_make(MODE_PACKET, OP_DATA, blk_no, $urandom_range(4095, bsz + 4), 0));
        blk_no++;
      end else if (pick < 73) begin
        offer(ev_make(MODE_TIMEOUT, 0, 0, 0, 0));
      end else if (pick < 78) begin
        offer(ev_make(MODE_PACKET, $urandom, blk_no, $urandom_range(3), $urandom));
      end else if (pick < 86) begin
        offer(ev_make(MODE_PACKET, OP_OACK, $urandom, $urandom_range(4095), pick_digit()));
      end else if (pick < 92) begin
        offer(ev_make(MODE_PACKET, OP_DATA, blk_no - 1, $urandom_range(4095, bsz + 4), 0));
      end else begin
        offer(random_event());
      end
    end
    bsz = big_blocks ? DOUBLE_SZ : SINGLE_SZ;
    if ($urandom_range(99) < 85)
      offer(ev_make(MODE_PACKET, OP_DATA, blk_no, $urandom_range(bsz + 3, HEADER_LEN), 0));
  endtask

  // register settings of the random part, extremes first
  task automatic apply_setting(input int idx);
    case (idx)
      0: begin
        write_reg(CFG_RETRY_LIMIT, 31'd1);
        write_reg(CFG_WANT_DOUBLE, 31'd0);
        write_reg(CFG_START_OFFSET, 31'd0);
        write_reg(CFG_MAX_BYTES, 31'h7FFF_FFFF);
      end
      1: begin
        write_reg(CFG_RETRY_LIMIT, 31'd255);
        write_reg(CFG_WANT_DOUBLE, 31'd1);
        write_reg(CFG_START_OFFSET, 31'h7FFF_FFFF);
        write_reg(CFG_MAX_BYTES, 31'h7FFF_FFFF);
      end
      2: begin
        write_reg(CFG_RETRY_LIMIT, $urandom_range(6, 2));
        write_reg(CFG_WANT_DOUBLE, $urandom_range(1));
        write_reg(CFG_START_OFFSET, $urandom);
        write_reg(CFG_MAX_BYTES, $urandom_range(40000, 3000));
      end
      3: begin
        write_reg(CFG_RETRY_LIMIT, 31'd0);
        write_reg(CFG_WANT_DOUBLE, 31'd1);
        write_reg(CFG_START_OFFSET, 31'd0);
        write_reg(CFG_MAX_BYTES, 31'd0);
      end
      4: begin
        write_reg(CFG_RETRY_LIMIT, $urandom_range(255, 1));
        write_reg(CFG_WANT_DOUBLE, $urandom_range(1));
        write_reg(CFG_START_OFFSET, $urandom);
        write_reg(CFG_MAX_BYTES, $urandom);
      end
      default: begin
        write_reg(CFG_RETRY_LIMIT, RETRY_LIMIT_RST);
        write_reg(CFG_WANT_DOUBLE, 31'd0);
        write_reg(CFG_START_OFFSET, 31'd0);
        write_reg(CFG_MAX_BYTES, MAX_BYTES_RST);
      end
    endcase
  endtask

  initial begin : stimulus
    int set_quota;
    int set_start;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // nothing happens while idle, unknown mode ignored
    plan_pinned(ev_make(MODE_TIMEOUT, 0, 0, 0, 0), 1'b0, '0);
    plan_pinned(ev_make(MODE_PACKET, OP_DATA, 1, 100, 0), 1'b0, '0);
    plan_pinned(ev_make(2'd3, 16'hFFFF, 16'hFFFF, 12'hFFF, 8'hFF), 1'b0, '0);
    // request, bad replies, retries until failure
    plan_pinned(ev_make(MODE_START, 0, 0, 0, 0), 1'b1,
                pin_result(SEND_REQUEST, '0, STAT_BUSY, '0));
    plan_pinned(ev_make(MODE_PACKET, OP_OACK, 0, 12, DIGIT_ONE), 1'b0, '0);
    plan_pinned(ev_make(MODE_PACKET, OP_DATA, 1, 100, 0), 1'b0, '0);
    plan_pinned(ev_make(MODE_TIMEOUT, 0, 0, 0, 0), 1'b1,
                pin_result(SEND_REQUEST, '0, STAT_BUSY, '0));
    plan_pinned(ev_make(MODE_TIMEOUT, 0, 0, 0, 0), 1'b1,
                pin_result(SEND_REQUEST, '0, STAT_BUSY, '0));
    plan_pinned(ev_make(MODE_TIMEOUT, 0, 0, 0, 0), 1'b1,
                pin_result(SEND_NONE, '0, STAT_FAILED, '0));
    plan_pinned(ev_make(MODE_PACKET, OP_OACK, 0, 13, DIGIT_ONE), 1'b0, '0);
    // full transfer: size correction, duplicate option acks, wrapped offsets, runt, short end
    plan_event(ev_make(MODE_START, 0, 0, 0, 0));
    plan_event(ev_make(MODE_PACKET, OP_OACK, 0, 13, DIGIT_TWO));
    plan_event(ev_make(MODE_PACKET, OP_DATA, 1, 4095, 0));
    plan_event(ev_make(MODE_PACKET, OP_OACK, 0, 4095, 8'hFF));
    plan_event(ev_make(MODE_PACKET, OP_OACK, 0, 12, DIGIT_ONE));
    plan_event(ev_make(MODE_PACKET, OP_OACK, 0, 13, DIGIT_ONE));
    plan_event(ev_make(MODE_PACKET, OP_DATA, 0, 2908, 0));
    plan_event(ev_make(MODE_PACKET, 16'hFFFF, 16'hFFFF, 100, 8'hFF));
    plan_event(ev_make(MODE_PACKET, OP_DATA, 9, 3, 0));
    plan_event(ev_make(MODE_PACKET, OP_DATA, 16'hFFFF, 2908, 0));
    plan_event(ev_make(MODE_PACKET, OP_DATA, 5, 4, 0));
    plan_pinned(ev_make(MODE_TIMEOUT, 0, 0, 0, 0), 1'b0, '0);
    // zero retry budget fails a start at once
    plan_cfg(CFG_RETRY_LIMIT, 31'd0);
    plan_pinned(ev_make(MODE_START, 0, 0, 0, 0), 1'b1,
                pin_result(SEND_NONE, '0, STAT_FAILED, '0));
    // oversize on the first block, double size wanted but single granted
    plan_cfg(CFG_RETRY_LIMIT, 31'd255);
    plan_cfg(CFG_MAX_BYTES, 31'd0);
    plan_cfg(CFG_WANT_DOUBLE, 31'd1);
    plan_cfg(CFG_START_OFFSET, 31'h7FFF_FFFF);
    plan_event(ev_make(MODE_START, 0, 0, 0, 0));
    plan_event(ev_make(MODE_PACKET, OP_OACK, 0, 13, DIGIT_ONE));
    plan_event(ev_make(MODE_PACKET, OP_DATA, 1, 1454, 0));

    foreach (test_plan[i]) begin
      if (test_plan[i].is_cfg) begin
        settle();
        write_reg(test_plan[i].cfg_idx, test_plan[i].cfg_val);
      end else begin
        offer_event(test_plan[i].ev, test_plan[i].pinned, test_plan[i].pinned_has,
                    test_plan[i].pinned_res);
      end
    end

    // random part over several register settings and idling patterns
    for (int cfg_set = 0; cfg_set < 6; cfg_set++) begin
      settle();
      apply_setting(cfg_set);
      send_gap_pct  = (cfg_set < 2) ? 10 : (cfg_set < 4) ? 53 : 0;
      recv_idle_pct = (cfg_set < 2) ? 53 : (cfg_set < 4) ? 10 : 0;
      set_start = items_sent;
      // long receiver hold-off while starts keep coming, so the input stalls
      if (cfg_set == 4) begin
        stall_request = 400;
        repeat (24) offer(ev_make(MODE_START, 0, 0, 0, 0));
      end
      set_quota = (cfg_set == 3) ? 60 : 160;
      while (items_sent - set_start < set_quota) begin
        if ($urandom_range(99) < 85) random_transfer();
        else offer(random_event());
      end
    end

    settle();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
